### src/gsp_pkg.sv
`default_nettype none

package gsp_pkg;

	// Frame phases of the bit engine.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	// Command frame: poll start, read-data command, then zero bytes.
	localparam logic [7:0] CMD_START = 8'h01;
	localparam logic [7:0] CMD_READ  = 8'h42;
	localparam logic [7:0] CMD_IDLE  = 8'h00;

	// Configuration register map.
	localparam int          CFG_ADDR_W       = 3;
	localparam logic [2:0]  ADDR_HALF_PERIOD = 3'd0;
	localparam logic [15:0] HALF_PERIOD_RST  = 16'd16;

	// Received bytes that feed the decoded fields.
	localparam int BYTE_MODE = 1;
	localparam int BYTE_BTN0 = 3;
	localparam int BYTE_LAST = 8;
	localparam int CAP_SLOTS = 7;

	// One result item; select_pin sits in bit 0.
	typedef struct packed {
		logic [7:0] left_stick_y;
		logic [7:0] left_stick_x;
		logic [7:0] right_stick_y;
		logic [7:0] right_stick_x;
		logic [7:0] buttons_high;
		logic [7:0] buttons_low;
		logic [7:0] mode_byte;
		logic       frame_done;
		logic       command_pin;
		logic       clock_pin;
		logic       select_pin;
	} gsp_result_t;

	function automatic logic [7:0] gsp_frame_cmd(input logic [31:0] idx);
		logic [7:0] cmd;
		if (idx == 32'd0) begin
			cmd = CMD_START;
		end else if (idx == 32'd1) begin
			cmd = CMD_READ;
		end else begin
			cmd = CMD_IDLE;
		end
		return cmd;
	endfunction

endpackage

`default_nettype wire

### src/gsp_cfg_regs.sv
`default_nettype none

module gsp_cfg_regs
	import gsp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output logic      [15:0]           half_period
);

	logic [15:0] half_period_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_HALF_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (wr_en) begin
			half_period_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_HALF_PERIOD) begin
			prdata = {16'd0, half_period_q};
		end
	end

	assign half_period = half_period_q;

endmodule

`default_nettype wire

### src/gsp_bit_engine.sv
`default_nettype none

module gsp_bit_engine
	import gsp_pkg::*;
#(
	parameter int FRAME_BYTES = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        action,
	input  wire logic        data_pin,
	input  wire logic [15:0] half_period,
	output gsp_result_t      result
);

	localparam int BW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	logic [1:0]    phase_q,   phase_n;
	logic [BW-1:0] byte_q,    byte_n;
	logic [2:0]    bit_q,     bit_n;
	logic [15:0]   wait_q,    wait_n;
	logic [7:0]    shift_q,   shift_n;
	logic          sel_q,     sel_n;
	logic          clk_lvl_q, clk_lvl_n;
	logic          cmd_q,     cmd_n;
	logic          done_n;
	logic [7:0]    cap_q [CAP_SLOTS];
	logic [7:0]    mode_q, btn_lo_q, btn_hi_q, rsx_q, rsy_q, lsx_q, lsy_q;
	logic [7:0]    mode_n, btn_lo_n, btn_hi_n, rsx_n, rsy_n, lsx_n, lsy_n;
	logic [15:0]   half_len;
	logic [15:0]   wait_inc;
	logic          enter;
	logic          sample;
	logic [7:0]    sample_bit;
	logic          capture;
	logic [7:0]    cmd_byte;

	assign half_len = (half_period == 16'd0) ? 16'd1 : half_period;
	assign wait_inc = wait_q + 16'd1;

	always_comb begin
		phase_n   = phase_q;
		byte_n    = byte_q;
		bit_n     = bit_q;
		wait_n    = wait_q;
		sel_n     = sel_q;
		clk_lvl_n = clk_lvl_q;
		cmd_n     = cmd_q;
		done_n    = 1'b0;
		enter     = 1'b0;
		sample    = 1'b0;
		cmd_byte  = CMD_IDLE;
		mode_n    = mode_q;
		btn_lo_n  = btn_lo_q;
		btn_hi_n  = btn_hi_q;
		rsx_n     = rsx_q;
		rsy_n     = rsy_q;
		lsx_n     = lsx_q;
		lsy_n     = lsy_q;

		unique case (phase_q)
			PH_IDLE: begin
				if (action) begin
					sel_n  = 1'b0;
					byte_n = '0;
					bit_n  = 3'd0;
					enter  = 1'b1;
				end
			end
			PH_LOW: begin
				if (wait_q >= half_len) begin
					phase_n   = PH_HIGH;
					clk_lvl_n = 1'b1;
					wait_n    = 16'd1;
				end else begin
					wait_n = wait_inc;
					sample = (wait_inc >= half_len);
				end
			end
			PH_HIGH: begin
				if (wait_q >= half_len) begin
					if (bit_q != 3'd7) begin
						bit_n = bit_q + 3'd1;
						enter = 1'b1;
					end else if ((32'(byte_q) + 32'd1) < 32'(FRAME_BYTES)) begin
						bit_n  = 3'd0;
						byte_n = byte_q + BW'(1);
						enter  = 1'b1;
					end else begin
						// Frame complete: release the lines and publish the fields.
						phase_n   = PH_IDLE;
						sel_n     = 1'b1;
						clk_lvl_n = 1'b1;
						cmd_n     = 1'b0;
						byte_n    = '0;
						bit_n     = 3'd0;
						wait_n    = 16'd0;
						done_n    = 1'b1;
						mode_n    = cap_q[0];
						btn_lo_n  = ~cap_q[1];
						btn_hi_n  = ~cap_q[2];
						rsx_n     = cap_q[3];
						rsy_n     = cap_q[4];
						lsx_n     = cap_q[5];
						lsy_n     = cap_q[6];
					end
				end else begin
					wait_n = wait_inc;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// First low tick of a bit: drive the command bit and start the count.
		if (enter) begin
			phase_n   = PH_LOW;
			clk_lvl_n = 1'b0;
			cmd_byte  = gsp_frame_cmd(32'(byte_n));
			cmd_n     = cmd_byte[bit_n];
			wait_n    = 16'd1;
			sample    = (half_len == 16'd1);
		end
	end

	assign sample_bit = {7'd0, data_pin} << bit_n;
	assign shift_n    = (bit_n == 3'd0) ? sample_bit : (shift_q | sample_bit);
	assign capture    = step && sample && (bit_n == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			byte_q    <= '0;
			bit_q     <= 3'd0;
			wait_q    <= 16'd0;
			shift_q   <= 8'd0;
			sel_q     <= 1'b1;
			clk_lvl_q <= 1'b1;
			cmd_q     <= 1'b0;
			mode_q    <= 8'd0;
			btn_lo_q  <= 8'd0;
			btn_hi_q  <= 8'd0;
			rsx_q     <= 8'd0;
			rsy_q     <= 8'd0;
			lsx_q     <= 8'd0;
			lsy_q     <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_n;
			byte_q    <= byte_n;
			bit_q     <= bit_n;
			wait_q    <= wait_n;
			sel_q     <= sel_n;
			clk_lvl_q <= clk_lvl_n;
			cmd_q     <= cmd_n;
			mode_q    <= mode_n;
			btn_lo_q  <= btn_lo_n;
			btn_hi_q  <= btn_hi_n;
			rsx_q     <= rsx_n;
			rsy_q     <= rsy_n;
			lsx_q     <= lsx_n;
			lsy_q     <= lsy_n;
			if (sample) begin
				shift_q <= shift_n;
			end
		end
	end

	// Only the bytes that are decoded are kept; the rest are shifted in and dropped.
	always_ff @(posedge clk) begin
		if (capture) begin
			if (32'(byte_n) == 32'(BYTE_MODE)) begin
				cap_q[0] <= shift_n;
			end
			for (int k = BYTE_BTN0; k <= BYTE_LAST; k++) begin
				if (32'(byte_n) == 32'(k)) begin
					cap_q[k - BYTE_BTN0 + 1] <= shift_n;
				end
			end
		end
	end

	always_comb begin
		result.select_pin    = sel_n;
		result.clock_pin     = clk_lvl_n;
		result.command_pin   = cmd_n;
		result.frame_done    = done_n;
		result.mode_byte     = mode_n;
		result.buttons_low   = btn_lo_n;
		result.buttons_high  = btn_hi_n;
		result.right_stick_x = rsx_n;
		result.right_stick_y = rsy_n;
		result.left_stick_x  = lsx_n;
		result.left_stick_y  = lsy_n;
	end

endmodule

`default_nettype wire

### src/gamepad_serial_poll_master.sv
`default_nettype none

// Serial poll master for a game controller. Every input transaction is one
// time tick: tuser bit 0 asks for a poll to start, tdata bit 0 is the level
// sampled on the controller data line. Every input transaction yields exactly
// one output transaction carrying the select, clock and command line levels
// after that tick, a frame-done flag, and the most recently decoded fields
// (mode byte, inverted button bytes and the four stick axes). A poll drops
// select and shifts out FRAME_BYTES command bytes (0x01, 0x42, then zeros),
// least significant bit first; each bit holds the clock low and then high for
// half_period_ticks ticks each (0 acts as 1), sampling the data line on the
// last low tick. Start requests while a frame runs are ignored. The block
// takes one transaction per clock cycle while the output side accepts results;
// each passes through the input register and then the result register, and
// both stall together only when the output side holds off. Write
// half_period_ticks through the APB port at byte address 0 while no poll is
// running.
module gamepad_serial_poll_master
	import gsp_pkg::*;
#(
	parameter int FRAME_BYTES = 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [0] data_pin
	input  wire logic [0:0]            s_axis_tuser,  // [0] action
	// Result stream.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [0] select_pin, [1] clock_pin, [2] command_pin, [3] frame_done,
	// [11:4] mode_byte, [19:12] buttons_low, [27:20] buttons_high,
	// [35:28] right_stick_x, [43:36] right_stick_y, [51:44] left_stick_x,
	// [59:52] left_stick_y, [63:60] zero
	output logic [63:0]                m_axis_tdata,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	logic        valid_s1;
	logic        action_s1;
	logic        data_s1;
	logic        out_valid_q;
	gsp_result_t out_q;
	gsp_result_t result;
	logic [15:0] half_period;
	logic        advance;
	logic        step;

	// The result register frees up when empty or when its transaction completes;
	// the input register moves on whenever the result register can take it.
	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	gsp_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.half_period (half_period)
	);

	gsp_bit_engine #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.action      (action_s1),
		.data_pin    (data_s1),
		.half_period (half_period),
		.result      (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser[0];
			data_s1   <= s_axis_tdata[0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q};

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

import gsp_pkg::*;

// Tracks the poll master tick by tick: line levels, bit timing, received bytes and
// the decoded fields. Every accepted tick queues the line state it should produce.
class poll_frame_checker;
	int unsigned  num_bytes;
	logic [15:0]  half_period;
	logic [1:0]   phase;
	int unsigned  byte_idx;
	int unsigned  bit_idx;
	int unsigned  wait_count;
	logic [7:0]   shift_reg;
	logic [7:0]   rx_bytes[];
	gsp_result_t  lines;
	gsp_result_t  line_states_due[$];
	int unsigned  failures;

	function new(int unsigned frame_bytes);
		num_bytes   = frame_bytes;
		half_period = HALF_PERIOD_RST;
		phase       = PH_IDLE;
		byte_idx    = 0;
		bit_idx     = 0;
		wait_count  = 0;
		shift_reg   = '0;
		rx_bytes    = new[frame_bytes];
		foreach (rx_bytes[i]) rx_bytes[i] = '0;
		lines             = '0;
		lines.select_pin  = 1'b1;
		lines.clock_pin   = 1'b1;
		failures    = 0;
	endfunction

	function void set_half_period(logic [15:0] value);
		half_period = value;
	endfunction

	function int unsigned ticks_per_half();
		return (half_period == 16'd0) ? 1 : half_period;
	endfunction

	function bit is_idle();
		return phase == PH_IDLE;
	endfunction

	// True when the next accepted tick will be the completion tick of the frame.
	function bit completes_next();
		return phase == PH_HIGH && wait_count >= ticks_per_half() && bit_idx == 7
			&& byte_idx + 1 >= num_bytes;
	endfunction

	function int unsigned pending();
		return line_states_due.size();
	endfunction

	function logic command_level();
		logic [7:0] cmd;
		case (byte_idx)
		0: cmd = CMD_START;
		1: cmd = CMD_READ;
		default: cmd = CMD_IDLE;
		endcase
		return cmd[bit_idx];
	endfunction

	function void take_bit(bit din);
		if (bit_idx == 0) begin
			shift_reg = '0;
		end
		shift_reg[bit_idx] = din;
		if (bit_idx == 7) begin
			rx_bytes[byte_idx] = shift_reg;
		end
	endfunction

	// First low tick of the current bit; with a one-tick half period it is also
	// the sampling tick.
	function void open_low(bit din);
		phase             = PH_LOW;
		lines.clock_pin   = 1'b0;
		lines.command_pin = command_level();
		wait_count        = 1;
		if (wait_count >= ticks_per_half()) begin
			take_bit(din);
		end
	endfunction

	function void close_frame();
		phase               = PH_IDLE;
		lines.select_pin    = 1'b1;
		lines.clock_pin     = 1'b1;
		lines.command_pin   = 1'b0;
		byte_idx            = 0;
		bit_idx             = 0;
		wait_count          = 0;
		lines.mode_byte     = rx_bytes[BYTE_MODE];
		lines.buttons_low   = ~rx_bytes[BYTE_BTN0];
		lines.buttons_high  = ~rx_bytes[BYTE_BTN0 + 1];
		lines.right_stick_x = rx_bytes[BYTE_BTN0 + 2];
		lines.right_stick_y = rx_bytes[BYTE_BTN0 + 3];
		lines.left_stick_x  = rx_bytes[BYTE_BTN0 + 4];
		lines.left_stick_y  = rx_bytes[BYTE_LAST];
	endfunction

	function void note_tick(bit act, bit din);
		int unsigned hl;
		hl = ticks_per_half();
		lines.frame_done = 1'b0;
		case (phase)
		PH_IDLE: begin
			if (act) begin
				lines.select_pin = 1'b0;
				byte_idx = 0;
				bit_idx  = 0;
				open_low(din);
			end
		end
		PH_LOW: begin
			if (wait_count >= hl) begin
				phase           = PH_HIGH;
				lines.clock_pin = 1'b1;
				wait_count      = 1;
			end else begin
				wait_count++;
				if (wait_count >= hl) begin
					take_bit(din);
				end
			end
		end
		default: begin
			if (wait_count >= hl) begin
				if (bit_idx < 7) begin
					bit_idx++;
					open_low(din);
				end else if (byte_idx + 1 < num_bytes) begin
					bit_idx = 0;
					byte_idx++;
					open_low(din);
				end else begin
					close_frame();
					lines.frame_done = 1'b1;
				end
			end else begin
				wait_count++;
			end
		end
		endcase
		line_states_due.push_back(lines);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(logic [63:0] data);
		gsp_result_t want;
		gsp_result_t got;
		if (line_states_due.size() == 0) begin
			$error("result transaction 0x%0h arrived with nothing expected", data);
			failures++;
			return;
		end
		want = line_states_due.pop_front();
		got  = data[59:0];
		compare_field("select_pin", want.select_pin, got.select_pin);
		compare_field("clock_pin", want.clock_pin, got.clock_pin);
		compare_field("command_pin", want.command_pin, got.command_pin);
		compare_field("frame_done", want.frame_done, got.frame_done);
		compare_field("mode_byte", want.mode_byte, got.mode_byte);
		compare_field("buttons_low", want.buttons_low, got.buttons_low);
		compare_field("buttons_high", want.buttons_high, got.buttons_high);
		compare_field("right_stick_x", want.right_stick_x, got.right_stick_x);
		compare_field("right_stick_y", want.right_stick_y, got.right_stick_y);
		compare_field("left_stick_x", want.left_stick_x, got.left_stick_x);
		compare_field("left_stick_y", want.left_stick_y, got.left_stick_y);
	endfunction
endclass

module testbench;

	localparam int NUM_BYTES = 9;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;   // [0] data_pin
	logic [0:0]            s_axis_tuser = '0;   // [0] action
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [0] select_pin, [1] clock_pin, [2] command_pin, [3] frame_done,
	// [11:4] mode_byte, [19:12] buttons_low, [27:20] buttons_high,
	// [35:28] right_stick_x, [43:36] right_stick_y, [51:44] left_stick_x,
	// [59:52] left_stick_y
	logic [63:0]           m_axis_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	poll_frame_checker     sb;
	int unsigned           ticks_sent = 0;
	// How the data line behaves over one frame: all zeros, all ones, or random.
	int unsigned           data_style = 2;

	gamepad_serial_poll_master #(
		.FRAME_BYTES(NUM_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Percentage of cycles in which one side holds off. The first 600 ticks have a
	// lazy receiver, the next 600 a lazy sender, the rest neither.
	function automatic int unsigned idle_pct(bit sender);
		if (ticks_sent < 600) begin
			return sender ? 17 : 73;
		end else if (ticks_sent < 1200) begin
			return sender ? 73 : 17;
		end
		return 0;
	endfunction

	// Offers one tick to the block and waits for the transaction. tvalid is left
	// high so that ticks can follow back to back.
	task automatic send_tick(input bit act, input bit din);
		while ($urandom_range(99) < idle_pct(1'b1)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, din};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_tick(act, din);
		ticks_sent++;
	endtask

	// One APB transfer: setup cycle, then access until pready. prdata is taken
	// at the completing edge, before the block updates anything. The bus then
	// goes idle.
	task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_half_period(input logic [15:0] want);
		logic [31:0] rdata;
		apb_access(1'b0, ADDR_HALF_PERIOD, '0, rdata);
		if (rdata[15:0] !== want) begin
			$error("half_period_ticks readback: expected 0x%0h, actual 0x%0h", want,
				rdata[15:0]);
			sb.failures++;
		end
	endtask

	// Every tick yields a result, so once the queue is empty the block is idle;
	// the wait that follows covers the two register stages.
	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(input logic [15:0] value);
		logic [31:0] unused;
		wait_drained();
		apb_access(1'b1, ADDR_HALF_PERIOD, {16'd0, value}, unused);
		sb.set_half_period(value);
		check_half_period(value);
	endtask

	// Random ticks. While idle, polls start often so most of the run sits inside
	// frames; inside a frame, stray start requests test that busy starts are
	// dropped, with extra weight on the completion tick. With close_out set, the
	// running frame is taken to its end before the stream goes quiet.
	task automatic run_ticks(input int unsigned count, input bit close_out);
		bit act;
		bit din;
		for (int unsigned n = 0; n < count || (close_out && !sb.is_idle()); n++) begin
			if (sb.is_idle()) begin
				act = ($urandom_range(3) == 0);
				if (act) begin
					data_style = $urandom_range(5);
				end
			end else if (sb.completes_next()) begin
				act = 1'($urandom_range(1));
			end else begin
				act = ($urandom_range(15) == 0);
			end
			if (n >= count) begin
				act = 1'b0;
			end
			case (data_style)
			0: din = 1'b0;
			1: din = 1'b1;
			default: din = 1'($urandom_range(1));
			endcase
			send_tick(act, din);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Result side: a random tready, every accepted result checked in order.
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
			m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	initial begin
		sb = new(NUM_BYTES);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of the register and the idle line levels with it.
		check_half_period(HALF_PERIOD_RST);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		s_axis_tvalid <= 1'b0;

		// A zero half period behaves as one tick. The start tick is already the
		// first low tick of bit 0; the starts that follow land on a busy frame.
		set_half_period(16'd0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		run_ticks(150, 1'b1);

		set_half_period(16'd1);
		run_ticks(250, 1'b1);
		set_half_period(16'd2);
		run_ticks(300, 1'b1);
		set_half_period(16'd3);
		run_ticks(400, 1'b1);

		// Widest half period: a frame would take millions of ticks, so only its
		// opening stretch is run and the block is left mid-frame.
		set_half_period(16'hFFFF);
		send_tick(1'b1, 1'b1);
		run_ticks(120, 1'b0);

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
